// ===== hw/rtl/terq_pkg.sv =====
// ----------------------------------------------------------------------------
// terq_pkg
// Shared types and codes for the timed event release queue.
// ----------------------------------------------------------------------------
package terq_pkg;

    localparam int DELAY_W = 16;
    localparam int TAG_W   = 16;
    localparam int TIME_W  = 32;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_TICK   = 1'b1;

    localparam logic STATUS_RELEASED = 1'b0;
    localparam logic STATUS_REJECTED = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } terq_in_t;

    typedef struct packed {
        logic               status;
        logic [DELAY_W-1:0] out_delay;
        logic [TAG_W-1:0]   out_tag;
    } terq_out_t;

    typedef struct packed {
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } terq_entry_t;

    // operation broadcast to every cell of the chain
    typedef struct packed {
        logic               ins;
        logic               pop;
        logic [DELAY_W-1:0] delay;
        logic [TAG_W-1:0]   tag;
    } terq_op_t;

endpackage

// ===== hw/rtl/timed_event_release_queue_core.sv =====
// ----------------------------------------------------------------------------
// timed_event_release_queue_core
// Event queue sorted by release time, built as a chain of compare-and-shift
// cells.
// ----------------------------------------------------------------------------
// An insert or a tick is accepted in every cycle while the two-entry output
// stage has room, since every cell of the chain decides locally whether to
// hold, take the new event, take its left neighbor or take its right
// neighbor. Results wait in a result register and a skid register; input
// stalls only when both hold a result. There is no clearing pass after reset;
// the fill count marks the occupied cells.
module timed_event_release_queue_core #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ev_valid,
    output logic               ev_ready,
    input  terq_pkg::terq_in_t  ev_data,
    output logic               res_valid,
    input  logic               res_ready,
    output terq_pkg::terq_out_t res_data
);
    import terq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [TIME_W-1:0] now_reg;
    logic [TIME_W-1:0] now_next;

    logic        accept;
    logic        full;
    logic        due;
    logic        space;
    logic        push;
    terq_out_t   push_data;
    terq_op_t    op;
    terq_entry_t cell_entry [QUEUE_DEPTH];
    logic        cell_keep  [QUEUE_DEPTH];

    assign ev_ready = space;
    assign accept   = ev_valid && ev_ready;
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));

    // saturating time counter
    assign now_next = (now_reg == {TIME_W{1'b1}}) ? now_reg : now_reg + TIME_W'(1);

    assign due = (count_reg != '0)
              && ({{(TIME_W-DELAY_W){1'b0}}, cell_entry[0].delay} <= now_next);

    always_comb
    begin
        op.ins       = accept && (ev_data.mode == MODE_INSERT) && !full;
        op.pop       = accept && (ev_data.mode == MODE_TICK) && due;
        op.delay     = ev_data.delay;
        op.tag       = ev_data.tag;
        push         = 1'b0;
        push_data    = '0;
        count_next   = count_reg;
        if (op.ins)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (op.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (accept && (ev_data.mode == MODE_INSERT) && full)
        begin
            push                = 1'b1;
            push_data.status    = STATUS_REJECTED;
            push_data.out_delay = ev_data.delay;
            push_data.out_tag   = ev_data.tag;
        end
        else if (op.pop)
        begin
            push                = 1'b1;
            push_data.status    = STATUS_RELEASED;
            push_data.out_delay = cell_entry[0].delay;
            push_data.out_tag   = cell_entry[0].tag;
        end
    end

    genvar i;
    generate
        for (i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic        occupied;
            logic        left_keep;
            terq_entry_t left_entry;
            terq_entry_t right_entry;

            assign occupied = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_head
                assign left_keep  = 1'b1;
                assign left_entry = cell_entry[0];
            end
            else
            begin : g_body
                assign left_keep  = cell_keep[i-1];
                assign left_entry = cell_entry[i-1];
            end

            if (i == QUEUE_DEPTH - 1)
            begin : g_tail
                assign right_entry = cell_entry[i];
            end
            else
            begin : g_inner
                assign right_entry = cell_entry[i+1];
            end

            terq_cell u_cell (
                .clk         (clk),
                .op          (op),
                .occupied    (occupied),
                .left_keep   (left_keep),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .keep        (cell_keep[i]),
                .entry       (cell_entry[i])
            );
        end
    endgenerate

    terq_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            now_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept && (ev_data.mode == MODE_TICK))
            begin
                now_reg <= now_next;
            end
        end
    end

endmodule

// ===== hw/rtl/terq_cell.sv =====
// ----------------------------------------------------------------------------
// terq_cell
// One slot of the sorted chain: holds, takes the new event or shifts.
// ----------------------------------------------------------------------------
module terq_cell (
    input  logic                 clk,
    input  terq_pkg::terq_op_t    op,
    input  logic                 occupied,
    input  logic                 left_keep,
    input  terq_pkg::terq_entry_t left_entry,
    input  terq_pkg::terq_entry_t right_entry,
    output logic                 keep,
    output terq_pkg::terq_entry_t entry
);
    import terq_pkg::*;

    terq_entry_t entry_reg;
    terq_entry_t entry_next;

    // entry stays in place on insert when it is due no later than the new one
    assign keep  = occupied && (entry_reg.delay <= op.delay);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (op.ins)
        begin
            if (!keep)
            begin
                if (left_keep)
                begin
                    entry_next.delay = op.delay;
                    entry_next.tag   = op.tag;
                end
                else
                begin
                    entry_next = left_entry;
                end
            end
        end
        else if (op.pop)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/terq_out_buf.sv =====
// ----------------------------------------------------------------------------
// terq_out_buf
// Two-entry output stage: result register plus skid register.
// ----------------------------------------------------------------------------
module terq_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  terq_pkg::terq_out_t push_data,
    output logic               space,
    output logic               res_valid,
    input  logic               res_ready,
    output terq_pkg::terq_out_t res_data
);
    import terq_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    terq_out_t out_data_reg;
    terq_out_t out_data_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    terq_out_t skid_data_reg;
    terq_out_t skid_data_next;
    logic      pop;

    assign pop       = out_valid_reg && res_ready;
    assign space     = !skid_valid_reg;
    assign res_valid = out_valid_reg;
    assign res_data  = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (out_valid_reg && !pop)
        begin
            if (push)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
        else
        begin
            out_valid_next = push;
            out_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
